// ----- src/ihf_pkg.sv -----
// Shared types and constants for the IPv4 header filter.
// Used by the front parser, the record queue, the verdict stage and the top level.
`default_nettype none

package ihf_pkg;

    localparam int MAX_PACKET = 1024;
    // The byte counter must be able to hold MAX_PACKET itself.
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);
    localparam int MIN_HEADER = 20;

    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    // Depth must be a power of two so that the pointers wrap on their own.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [3:0] {
        VERDICT_ICMP      = 4'd0,
        VERDICT_TCP       = 4'd1,
        VERDICT_UDP       = 4'd2,
        VERDICT_SHORT     = 4'd3,
        VERDICT_VERSION   = 4'd4,
        VERDICT_HDR_LEN   = 4'd5,
        VERDICT_TOTAL_LEN = 4'd6,
        VERDICT_CHECKSUM  = 4'd7,
        VERDICT_NOT_LOCAL = 4'd8,
        VERDICT_UNKNOWN   = 4'd9
    } verdict_t;

    // Everything captured from one packet, handed from the parser to the verdict stage.
    typedef struct packed {
        logic [CNT_W-1:0] rx_length;
        logic [7:0]       version_and_length;
        logic [15:0]      total_length;
        logic [15:0]      stored_checksum;
        logic [15:0]      running_sum;
        logic [7:0]       protocol_number;
        logic [31:0]      dest_address;
        logic [31:0]      sender_address;
    } pkt_rec_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic [15:0] payload_length;
        logic [5:0]  payload_offset;
        verdict_t    verdict;
    } result_t;

endpackage

`default_nettype wire

// ----- src/ihf_front.sv -----
// Byte-wise header parser: captures header fields and keeps the ones'-complement sum.
// Pushes one packet record per packet into the record queue. Depends on ihf_pkg.
`default_nettype none

module ihf_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_valid,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last_byte,
    output ihf_pkg::pkt_rec_t    rec,
    output logic                 rec_push
);

    localparam logic [ihf_pkg::CNT_W-1:0] IDX_VER_IHL = ihf_pkg::CNT_W'(0);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_TLEN_HI = ihf_pkg::CNT_W'(2);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_TLEN_LO = ihf_pkg::CNT_W'(3);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_PROTO   = ihf_pkg::CNT_W'(9);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_CSUM_HI = ihf_pkg::CNT_W'(10);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_CSUM_LO = ihf_pkg::CNT_W'(11);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_SRC_LO  = ihf_pkg::CNT_W'(12);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_DST_LO  = ihf_pkg::CNT_W'(16);
    localparam logic [ihf_pkg::CNT_W-1:0] IDX_DST_HI  = ihf_pkg::CNT_W'(19);
    localparam logic [ihf_pkg::CNT_W-1:0] CNT_MAX     = ihf_pkg::CNT_W'(ihf_pkg::MAX_PACKET);

    logic [ihf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]                ver_len_reg, ver_len_next;
    logic [15:0]               total_reg, total_next;
    logic [15:0]               csum_reg, csum_next;
    logic [15:0]               sum_reg, sum_next;
    logic [7:0]                pending_reg, pending_next;
    logic [7:0]                proto_reg, proto_next;
    logic [31:0]               dest_reg, dest_next;
    logic [31:0]               sender_reg, sender_next;

    logic        active;
    logic [5:0]  ihl_bytes;
    logic [15:0] word;
    logic [16:0] sum_wide;

    assign active    = count_reg < CNT_MAX;
    assign ihl_bytes = {ver_len_reg[3:0], 2'b00};
    assign word      = {pending_reg, (count_reg == IDX_CSUM_LO) ? 8'h00 : data_byte};
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, word};

    always_comb
    begin
        count_next   = count_reg;
        ver_len_next = ver_len_reg;
        total_next   = total_reg;
        csum_next    = csum_reg;
        sum_next     = sum_reg;
        pending_next = pending_reg;
        proto_next   = proto_reg;
        dest_next    = dest_reg;
        sender_next  = sender_reg;
        if (active)
        begin
            count_next = count_reg + ihf_pkg::CNT_W'(1);
            if (count_reg == IDX_VER_IHL) ver_len_next = data_byte;
            if (count_reg == IDX_TLEN_HI) total_next = {data_byte, total_reg[7:0]};
            if (count_reg == IDX_TLEN_LO) total_next = {total_reg[15:8], data_byte};
            if (count_reg == IDX_PROTO)   proto_next = data_byte;
            if (count_reg == IDX_CSUM_HI) csum_next = {data_byte, csum_reg[7:0]};
            if (count_reg == IDX_CSUM_LO) csum_next = {csum_reg[15:8], data_byte};
            if (count_reg >= IDX_SRC_LO && count_reg < IDX_DST_LO)
                sender_next = {sender_reg[23:0], data_byte};
            if (count_reg >= IDX_DST_LO && count_reg <= IDX_DST_HI)
                dest_next = {dest_reg[23:0], data_byte};
            // Even bytes are the high half of a header word; the checksum word sums as zero.
            if (!count_reg[0])
                pending_next = (count_reg == IDX_CSUM_HI) ? 8'h00 : data_byte;
            else if (16'(count_reg) < 16'(ihl_bytes))
                sum_next = sum_wide[15:0] + 16'(sum_wide[16]);
        end
    end

    always_comb
    begin
        rec.rx_length          = count_next;
        rec.version_and_length = ver_len_next;
        rec.total_length       = total_next;
        rec.stored_checksum    = csum_next;
        rec.running_sum        = sum_next;
        rec.protocol_number    = proto_next;
        rec.dest_address       = dest_next;
        rec.sender_address     = sender_next;
    end

    assign rec_push = byte_valid && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ver_len_reg <= '0;
            total_reg   <= '0;
            csum_reg    <= '0;
            sum_reg     <= '0;
            pending_reg <= '0;
            proto_reg   <= '0;
            dest_reg    <= '0;
            sender_reg  <= '0;
        end
        else if (byte_valid)
        begin
            if (last_byte)
            begin
                // Packet done: its record goes to the queue, state starts over.
                count_reg   <= '0;
                ver_len_reg <= '0;
                total_reg   <= '0;
                csum_reg    <= '0;
                sum_reg     <= '0;
                pending_reg <= '0;
                proto_reg   <= '0;
                dest_reg    <= '0;
                sender_reg  <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                ver_len_reg <= ver_len_next;
                total_reg   <= total_next;
                csum_reg    <= csum_next;
                sum_reg     <= sum_next;
                pending_reg <= pending_next;
                proto_reg   <= proto_next;
                dest_reg    <= dest_next;
                sender_reg  <= sender_next;
            end
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("byte counter passed its saturation limit");

endmodule

`default_nettype wire

// ----- src/ihf_fifo.sv -----
// Short queue of packet records between the parser and the verdict stage.
// Depends on ihf_pkg.
`default_nettype none

module ihf_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ihf_pkg::pkt_rec_t push_rec,
    output logic                  full,
    input  wire logic             pop,
    output ihf_pkg::pkt_rec_t     head_rec,
    output logic                  empty
);

    ihf_pkg::pkt_rec_t           entry_reg [ihf_pkg::FIFO_DEPTH];
    logic [ihf_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [ihf_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [ihf_pkg::FIFO_CW-1:0] fill_reg;

    assign full     = fill_reg == ihf_pkg::FIFO_CW'(ihf_pkg::FIFO_DEPTH);
    assign empty    = fill_reg == '0;
    assign head_rec = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + ihf_pkg::FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + ihf_pkg::FIFO_AW'(1);
            if (push && !pop)
                fill_reg <= fill_reg + ihf_pkg::FIFO_CW'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - ihf_pkg::FIFO_CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("record pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("record popped from an empty queue");

    a_fill_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) || (fill_reg == ihf_pkg::FIFO_CW'(ihf_pkg::FIFO_DEPTH))
        || (wr_ptr_reg != rd_ptr_reg))
        else $error("fill count disagrees with queue pointers");

endmodule

`default_nettype wire

// ----- src/ihf_back.sv -----
// Verdict stage: checks one packet record and holds the result in an output register.
// Depends on ihf_pkg.
`default_nettype none

module ihf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ihf_pkg::pkt_rec_t head_rec,
    input  wire logic             empty,
    output logic                  pop,
    input  wire logic [31:0]      local_address,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ihf_pkg::result_t      out_result
);

    logic                    out_valid_reg;
    ihf_pkg::result_t        out_result_reg;
    ihf_pkg::result_t        result_next;

    logic [15:0] len16;
    logic [5:0]  ihl_bytes;
    logic [15:0] ihl16;
    logic [15:0] calc_sum;

    assign len16     = 16'(head_rec.rx_length);
    assign ihl_bytes = {head_rec.version_and_length[3:0], 2'b00};
    assign ihl16     = 16'(ihl_bytes);
    assign calc_sum  = ~head_rec.running_sum;

    always_comb
    begin
        // First failing check wins.
        if (len16 < 16'(ihf_pkg::MIN_HEADER))
            result_next.verdict = ihf_pkg::VERDICT_SHORT;
        else if (head_rec.version_and_length[7:4] != ihf_pkg::IPV4_VERSION)
            result_next.verdict = ihf_pkg::VERDICT_VERSION;
        else if (ihl16 < 16'(ihf_pkg::MIN_HEADER) || ihl16 > len16)
            result_next.verdict = ihf_pkg::VERDICT_HDR_LEN;
        else if (head_rec.total_length > len16)
            result_next.verdict = ihf_pkg::VERDICT_TOTAL_LEN;
        else if (calc_sum != head_rec.stored_checksum)
            result_next.verdict = ihf_pkg::VERDICT_CHECKSUM;
        else if (head_rec.dest_address != local_address)
            result_next.verdict = ihf_pkg::VERDICT_NOT_LOCAL;
        else if (head_rec.protocol_number == ihf_pkg::PROTO_ICMP)
            result_next.verdict = ihf_pkg::VERDICT_ICMP;
        else if (head_rec.protocol_number == ihf_pkg::PROTO_TCP)
            result_next.verdict = ihf_pkg::VERDICT_TCP;
        else if (head_rec.protocol_number == ihf_pkg::PROTO_UDP)
            result_next.verdict = ihf_pkg::VERDICT_UDP;
        else
            result_next.verdict = ihf_pkg::VERDICT_UNKNOWN;

        result_next.payload_offset = ihl_bytes;
        result_next.payload_length = (head_rec.total_length >= ihl16)
                                     ? head_rec.total_length - ihl16 : 16'd0;
        result_next.source_address = head_rec.sender_address;
    end

    assign pop        = !empty && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ----- src/ipv4_header_filter.sv -----
// IPv4 receive-header filter: takes one packet byte per transfer (tlast on the final byte)
// and gives one result transfer per packet with the verdict, payload offset, payload
// length and source address. Input bytes are taken at one per clock while s_tready is
// high; the parser keeps a single 16-bit end-around add per header word. The result
// passes from the last byte through a two-entry record queue and an output register,
// so the input stalls only when both queue entries are waiting on a stalled output.
// Bytes beyond MAX_PACKET count toward nothing. No clearing pass is needed after reset.
// Depends on ihf_pkg, ihf_front, ihf_fifo and ihf_back.
`default_nettype none

module ipv4_header_filter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ihf_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic                             s_tlast,   // last_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [3:0] verdict, [9:4] payload_offset, [25:10] payload_length,
    // [57:26] source_address, [63:58] zero
    output logic [ihf_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [31:0]                      cfg_data   // local_address
);

    logic [31:0]        local_addr_reg;
    logic               byte_xfer;
    ihf_pkg::pkt_rec_t  push_rec;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    ihf_pkg::pkt_rec_t  head_rec;
    ihf_pkg::result_t   out_result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign byte_xfer = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_addr_reg <= '0;
        else if (cfg_valid && cfg_ready)
            local_addr_reg <= cfg_data;
    end

    ihf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_xfer),
        .data_byte  (s_tdata[7:0]),
        .last_byte  (s_tlast),
        .rec        (push_rec),
        .rec_push   (push)
    );

    ihf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .head_rec (head_rec),
        .empty    (empty)
    );

    ihf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_rec      (head_rec),
        .empty         (empty),
        .pop           (pop),
        .local_address (local_addr_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (out_result)
    );

    assign m_tdata = {6'b0,
                      out_result.source_address,
                      out_result.payload_length,
                      out_result.payload_offset,
                      out_result.verdict};

endmodule

`default_nettype wire
